// ===== rtl/core/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and defaults for the complex fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_req_op;

    typedef struct packed {
        logic is_add;
        logic is_sub;
        logic is_mul;
        logic is_div;
    } t_req_cls;

    localparam int CLS_BITS = $bits(t_req_cls);

endpackage

// ===== rtl/core/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Input side: decodes the operation of each item and packs it for the queue.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    input  logic                                    i_in_valid,
    input  logic [1:0]                              i_req_type,
    input  logic signed [DATA_WIDTH-1:0]            i_a_re,
    input  logic signed [DATA_WIDTH-1:0]            i_a_im,
    input  logic signed [DATA_WIDTH-1:0]            i_b_re,
    input  logic signed [DATA_WIDTH-1:0]            i_b_im,
    input  logic                                    i_q_full,
    output logic                                    o_in_stall,
    output logic                                    o_push,
    output logic [cau_pkg::CLS_BITS+4*DATA_WIDTH-1:0] o_item
);

    cau_pkg::t_req_cls cls;

    always_comb begin
        cls = '0;
        case (cau_pkg::t_req_op'(i_req_type))
            cau_pkg::OP_ADD: cls.is_add = 1'b1;
            cau_pkg::OP_SUB: cls.is_sub = 1'b1;
            cau_pkg::OP_MUL: cls.is_mul = 1'b1;
            cau_pkg::OP_DIV: cls.is_div = 1'b1;
            default:         cls.is_add = 1'b1;
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign o_item     = {cls, i_a_re, i_a_im, i_b_re, i_b_im};

endmodule

// ===== rtl/core/cau_queue.sv =====
// ----------------------------------------------------------------------------
// cau_queue
// Short FIFO between the front and the execution pipeline.
// ----------------------------------------------------------------------------
module cau_queue #(
    parameter int ITEM_WIDTH = 8,
    parameter int DEPTH      = cau_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [ITEM_WIDTH-1:0] i_item,
    input  logic                  i_pop,
    output logic [ITEM_WIDTH-1:0] o_item,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [ITEM_WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]         r_wptr, n_wptr;
    logic [AW-1:0]         r_rptr, n_rptr;
    logic [CW-1:0]         r_cnt,  n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rptr];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));

endmodule

// ===== rtl/core/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, sums, rescale or divide setup, a radix-2
// divider stage per quotient bit, and the output register.
// ----------------------------------------------------------------------------
module cau_back #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_q_empty,
    input  logic [cau_pkg::CLS_BITS+4*DATA_WIDTH-1:0] i_item,
    output logic                                    o_pop,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [DATA_WIDTH-1:0]            o_res_re,
    output logic signed [DATA_WIDTH-1:0]            o_res_im,
    output logic                                    o_saturated,
    output logic                                    o_div_zero
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int NW = 2 * W + F;
    localparam int CW = 3 * W + F;

    localparam logic signed [SW-1:0] MAXS = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINS = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic                  valid;
        cau_pkg::t_req_cls     cls;
        logic signed [PW-1:0]  pac;
        logic signed [PW-1:0]  pbd;
        logic signed [PW-1:0]  pad;
        logic signed [PW-1:0]  pbc;
        logic        [PW-1:0]  pcc;
        logic        [PW-1:0]  pdd;
        logic signed [W-1:0]   as_re;
        logic signed [W-1:0]   as_im;
        logic                  as_sat;
    } t_s1;

    typedef struct packed {
        logic                  valid;
        cau_pkg::t_req_cls     cls;
        logic signed [SW-1:0]  s_re;
        logic signed [SW-1:0]  s_im;
        logic        [PW-1:0]  den;
        logic signed [W-1:0]   as_re;
        logic signed [W-1:0]   as_im;
        logic                  as_sat;
    } t_s2;

    typedef struct packed {
        logic                  valid;
        logic                  is_div;
        logic signed [W-1:0]   res_re;
        logic signed [W-1:0]   res_im;
        logic                  sat;
        logic                  dz;
        logic        [PW-1:0]  den;
        logic                  neg_re;
        logic                  neg_im;
        logic                  dsat_re;
        logic                  dsat_im;
        logic        [NW-1:0]  rem_re;
        logic        [NW-1:0]  rem_im;
        logic        [W-1:0]   q_re;
        logic        [W-1:0]   q_im;
    } t_stg;

    typedef struct packed {
        logic                  valid;
        logic signed [W-1:0]   res_re;
        logic signed [W-1:0]   res_im;
        logic                  sat;
        logic                  dz;
    } t_out;

    function automatic logic [W:0] clip(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > MAXS) begin
            r = {1'b1, MAXV};
        end else if (v < MINS) begin
            r = {1'b1, MINV};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    function automatic logic div_sat(input logic [NW-1:0] num, input logic [PW-1:0] den,
                                     input logic neg);
        logic [CW-1:0] thr;
        thr = ({{(CW-PW){1'b0}}, den} << (W - 1))
            + (neg ? {{(CW-PW){1'b0}}, den} : '0);
        return {{(CW-NW){1'b0}}, num} >= thr;
    endfunction

    logic en;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_stg r_d [W+1];
    t_stg n_d [W+1];
    t_out r_out, n_out;

    logic signed [W-1:0] q_a_re, q_a_im, q_b_re, q_b_im;
    cau_pkg::t_req_cls   q_cls;

    assign en    = !(r_out.valid && i_out_stall);
    assign o_pop = en && !i_q_empty;
    assign {q_cls, q_a_re, q_a_im, q_b_re, q_b_im} = i_item;

    // stage 1: products and add/sub
    always_comb begin
        logic signed [SW-1:0] t_re, t_im;
        logic [W:0]           c_re, c_im;
        n_s1.valid = o_pop;
        n_s1.cls   = q_cls;
        n_s1.pac   = q_a_re * q_b_re;
        n_s1.pbd   = q_a_im * q_b_im;
        n_s1.pad   = q_a_re * q_b_im;
        n_s1.pbc   = q_a_im * q_b_re;
        n_s1.pcc   = PW'(q_b_re * q_b_re);
        n_s1.pdd   = PW'(q_b_im * q_b_im);
        if (q_cls.is_sub) begin
            t_re = SW'(q_a_re) - SW'(q_b_re);
            t_im = SW'(q_a_im) - SW'(q_b_im);
        end else begin
            t_re = SW'(q_a_re) + SW'(q_b_re);
            t_im = SW'(q_a_im) + SW'(q_b_im);
        end
        c_re         = clip(t_re);
        c_im         = clip(t_im);
        n_s1.as_re   = c_re[W-1:0];
        n_s1.as_im   = c_im[W-1:0];
        n_s1.as_sat  = c_re[W] | c_im[W];
    end

    // stage 2: product sums and divisor
    always_comb begin
        n_s2.valid  = r_s1.valid;
        n_s2.cls    = r_s1.cls;
        n_s2.as_re  = r_s1.as_re;
        n_s2.as_im  = r_s1.as_im;
        n_s2.as_sat = r_s1.as_sat;
        n_s2.den    = r_s1.pcc + r_s1.pdd;
        if (r_s1.cls.is_div) begin
            n_s2.s_re = SW'(r_s1.pac) + SW'(r_s1.pbd);
            n_s2.s_im = SW'(r_s1.pbc) - SW'(r_s1.pad);
        end else begin
            n_s2.s_re = SW'(r_s1.pac) - SW'(r_s1.pbd);
            n_s2.s_im = SW'(r_s1.pad) + SW'(r_s1.pbc);
        end
    end

    // stage 3: rescale for multiply, setup for divide
    always_comb begin
        logic [W:0]           c_re, c_im;
        logic signed [SW-1:0] m_re, m_im;
        logic        [NW-1:0] num_re, num_im;
        c_re   = clip(r_s2.s_re >>> F);
        c_im   = clip(r_s2.s_im >>> F);
        m_re   = r_s2.s_re[SW-1] ? -r_s2.s_re : r_s2.s_re;
        m_im   = r_s2.s_im[SW-1] ? -r_s2.s_im : r_s2.s_im;
        num_re = NW'(m_re[PW-1:0]) << F;
        num_im = NW'(m_im[PW-1:0]) << F;
        n_d[0].valid   = r_s2.valid;
        n_d[0].is_div  = r_s2.cls.is_div;
        n_d[0].den     = r_s2.den;
        n_d[0].neg_re  = r_s2.s_re[SW-1];
        n_d[0].neg_im  = r_s2.s_im[SW-1];
        n_d[0].dsat_re = div_sat(num_re, r_s2.den, r_s2.s_re[SW-1]);
        n_d[0].dsat_im = div_sat(num_im, r_s2.den, r_s2.s_im[SW-1]);
        n_d[0].rem_re  = num_re;
        n_d[0].rem_im  = num_im;
        n_d[0].q_re    = '0;
        n_d[0].q_im    = '0;
        n_d[0].dz      = r_s2.cls.is_div && (r_s2.den == '0);
        if (r_s2.cls.is_mul) begin
            n_d[0].res_re = c_re[W-1:0];
            n_d[0].res_im = c_im[W-1:0];
            n_d[0].sat    = c_re[W] | c_im[W];
        end else if (r_s2.cls.is_div) begin
            n_d[0].res_re = '0;
            n_d[0].res_im = '0;
            n_d[0].sat    = 1'b0;
        end else begin
            n_d[0].res_re = r_s2.as_re;
            n_d[0].res_im = r_s2.as_im;
            n_d[0].sat    = r_s2.as_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid   <= 1'b0;
            r_s2.valid   <= 1'b0;
            r_d[0].valid <= 1'b0;
        end else if (en) begin
            r_s1   <= n_s1;
            r_s2   <= n_s2;
            r_d[0] <= n_d[0];
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 0; j < W; j++) begin : g_div
        localparam int K = W - 1 - j;
        always_comb begin
            logic [CW-1:0] trial;
            n_d[j+1] = r_d[j];
            trial    = {{(CW-PW){1'b0}}, r_d[j].den} << K;
            if ({{(CW-NW){1'b0}}, r_d[j].rem_re} >= trial) begin
                n_d[j+1].rem_re  = r_d[j].rem_re - trial[NW-1:0];
                n_d[j+1].q_re[K] = 1'b1;
            end
            if ({{(CW-NW){1'b0}}, r_d[j].rem_im} >= trial) begin
                n_d[j+1].rem_im  = r_d[j].rem_im - trial[NW-1:0];
                n_d[j+1].q_im[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d[j+1].valid <= 1'b0;
            end else if (en) begin
                r_d[j+1] <= n_d[j+1];
            end
        end
    end

    always_comb begin
        n_out.valid  = r_d[W].valid;
        n_out.res_re = r_d[W].res_re;
        n_out.res_im = r_d[W].res_im;
        n_out.sat    = r_d[W].sat;
        n_out.dz     = r_d[W].dz;
        if (r_d[W].is_div && !r_d[W].dz) begin
            if (r_d[W].dsat_re) begin
                n_out.res_re = r_d[W].neg_re ? MINV : MAXV;
            end else begin
                n_out.res_re = r_d[W].neg_re ? -r_d[W].q_re : r_d[W].q_re;
            end
            if (r_d[W].dsat_im) begin
                n_out.res_im = r_d[W].neg_im ? MINV : MAXV;
            end else begin
                n_out.res_im = r_d[W].neg_im ? -r_d[W].q_im : r_d[W].q_im;
            end
            n_out.sat = r_d[W].dsat_re | r_d[W].dsat_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out.valid;
    assign o_res_re    = r_out.res_re;
    assign o_res_im    = r_out.res_im;
    assign o_saturated = r_out.sat;
    assign o_div_zero  = r_out.dz;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid && r_out.dz |-> r_out.res_re == '0 && r_out.res_im == '0 && !r_out.sat)
        else $error("zero divisor result not cleared");

    a_dz_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d[0].valid && !r_d[0].is_div |-> !r_d[0].dz)
        else $error("zero divisor flag on non-divide");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid && r_out.sat |-> r_out.res_re == MAXV || r_out.res_re == MINV
                                   || r_out.res_im == MAXV || r_out.res_im == MINV)
        else $error("saturation flag without clipped part");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_d[W]) && $stable(r_s1))
        else $error("pipeline moved while output stalled");

endmodule

// ===== rtl/core/complex_alu_fixed.sv =====
// ----------------------------------------------------------------------------
// complex_alu_fixed
// Complex add, subtract, multiply and divide on signed fixed-point parts.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one item (operation code and
// two complex operands). Output channel: o_out_valid / i_out_stall carry one
// result item (real and imaginary part, saturation and zero-divisor flags).
// An item is taken on a clock edge with valid high and stall low.
// Throughput: one item per cycle unless a stall holds the pipeline. From input
// acceptance to output valid an item passes the queue write, products, sums,
// rescale/divide setup, one divider stage per quotient bit and the output
// register. The divider stage chain sets the latency.
// A 4-entry queue decouples the input side; o_in_stall rises when it is full.
// When i_out_stall is high with a result pending, the whole execution pipeline
// holds and the queue absorbs up to 4 more items.
// Reset (i_rst_n low, synchronous) empties the queue and the pipeline.
// ----------------------------------------------------------------------------
module complex_alu_fixed #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_req_type,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic                         o_saturated,
    output logic                         o_div_zero
);

    localparam int IW = cau_pkg::CLS_BITS + 4 * DATA_WIDTH;

    logic          q_full, q_empty, push, pop;
    logic [IW-1:0] f_item, q_item;

    cau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_a_re     (i_a_re),
        .i_a_im     (i_a_im),
        .i_b_re     (i_b_re),
        .i_b_im     (i_b_im),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_item     (f_item)
    );

    cau_queue #(.ITEM_WIDTH(IW), .DEPTH(cau_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res_re    (o_res_re),
        .o_res_im    (o_res_im),
        .o_saturated (o_saturated),
        .o_div_zero  (o_div_zero)
    );

endmodule

// ===== dv/tb_complex_alu_fixed.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_complex_alu_fixed
// Self-checking bench for the complex fixed-point ALU: a directed table
// followed by random requests, each result checked against a table entry or a
// Q8.8 predictor while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_complex_alu_fixed;
    import cau_pkg::*;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam longint MAXV = (64'sd1 <<< (DW - 1)) - 1;
    localparam longint MINV = -(64'sd1 <<< (DW - 1));
    localparam int N_RANDOM = 1730;

    typedef struct {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 sat;
        logic                 dz;
    } t_cplx_res;

    typedef struct {
        t_req_op              op;
        logic signed [DW-1:0] ar, ai, br, bi;
        bit                   typed;
        t_cplx_res            res;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_req_type = '0;
    logic signed [DW-1:0] i_a_re = '0, i_a_im = '0, i_b_re = '0, i_b_im = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [DW-1:0] o_res_re, o_res_im;
    logic                 o_saturated, o_div_zero;

    t_cplx_res pending_res[$];
    int        n_errors = 0;
    int        n_results = 0;
    int        n_div_zero = 0;
    int        n_sat = 0;
    bit        quiet = 1'b0;
    int        sink_wait = 0;

    complex_alu_fixed dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("complex_alu_fixed test failed");
        $finish;
    end

    function automatic longint sat_clip(longint v, ref logic sat);
        if (v > MAXV) begin
            sat = 1'b1;
            return MAXV;
        end
        if (v < MINV) begin
            sat = 1'b1;
            return MINV;
        end
        return v;
    endfunction

    function automatic t_cplx_res cplx_predict(t_req_op op, longint a, longint b,
                                               longint c, longint d);
        t_cplx_res r;
        longint    den;
        r.sat = 1'b0;
        r.dz  = 1'b0;
        r.re  = '0;
        r.im  = '0;
        case (op)
            OP_ADD: begin
                r.re = DW'(sat_clip(a + c, r.sat));
                r.im = DW'(sat_clip(b + d, r.sat));
            end
            OP_SUB: begin
                r.re = DW'(sat_clip(a - c, r.sat));
                r.im = DW'(sat_clip(b - d, r.sat));
            end
            OP_MUL: begin
                r.re = DW'(sat_clip((a * c - b * d) >>> FB, r.sat));
                r.im = DW'(sat_clip((a * d + b * c) >>> FB, r.sat));
            end
            default: begin
                den = c * c + d * d;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    // signed divide truncates toward zero
                    r.re = DW'(sat_clip(((a * c + b * d) <<< FB) / den, r.sat));
                    r.im = DW'(sat_clip(((b * c - a * d) <<< FB) / den, r.sat));
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [DW-1:0] rand_part();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? MAXV[DW-1:0] : MINV[DW-1:0];
            1: return DW'($signed(DW'($urandom_range(0, 1023))) - 512);
            2: return '0;
            default: return DW'($urandom());
        endcase
    endfunction

    task automatic send_item(t_req_op op, logic signed [DW-1:0] ar, ai, br, bi,
                             bit typed, t_cplx_res typed_res);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= op;
        i_a_re     <= ar;
        i_a_im     <= ai;
        i_b_re     <= br;
        i_b_im     <= bi;
        do @(posedge i_clk); while (o_in_stall);
        pending_res.push_back(typed ? typed_res : cplx_predict(op, ar, ai, br, bi));
    endtask

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            if (pending_res.size() == 0) begin
                $error("unexpected result item re=%0d im=%0d", o_res_re, o_res_im);
                n_errors++;
            end else begin
                t_cplx_res e;
                e = pending_res.pop_front();
                if (o_res_re !== e.re) begin
                    $error("res_re expected %0d actual %0d", e.re, o_res_re);
                    n_errors++;
                end
                if (o_res_im !== e.im) begin
                    $error("res_im expected %0d actual %0d", e.im, o_res_im);
                    n_errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated expected %0b actual %0b", e.sat, o_saturated);
                    n_errors++;
                end
                if (o_div_zero !== e.dz) begin
                    $error("div_zero expected %0b actual %0b", e.dz, o_div_zero);
                    n_errors++;
                end
                n_sat      += e.sat;
                n_div_zero += e.dz;
            end
            n_results++;
            sink_wait = quiet ? 0 : $urandom_range(0, 11);
        end
        if (sink_wait > 0) begin
            i_out_stall <= 1'b1;
            sink_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    t_row rows[] = '{
        '{OP_ADD, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1, '{16'sh0, 16'sh0, 0, 0}},
        '{OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1,
          '{16'sh7fff, 16'sh7fff, 1, 0}},
        '{OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1,
          '{16'sh8000, 16'sh8000, 1, 0}},
        '{OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1,
          '{16'sh8000, 16'sh7fff, 1, 0}},
        '{OP_SUB, 16'sh0100, 16'sh0200, 16'sh0100, 16'sh0200, 1, '{16'sh0, 16'sh0, 0, 0}},
        '{OP_MUL, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000, 1,
          '{16'sh0100, 16'sh0, 0, 0}},
        '{OP_MUL, 16'sh0000, 16'sh0100, 16'sh0000, 16'sh0100, 1,
          '{-16'sh0100, 16'sh0, 0, 0}},
        '{OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, '{0, 0, 0, 0}},
        '{OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, '{0, 0, 0, 0}},
        '{OP_MUL, 16'shffff, 16'sh0001, 16'sh0001, 16'sh0001, 0, '{0, 0, 0, 0}},
        '{OP_MUL, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 0, '{0, 0, 0, 0}},
        '{OP_DIV, 16'sh1234, 16'sh8000, 16'sh0000, 16'sh0000, 1, '{16'sh0, 16'sh0, 0, 1}},
        '{OP_DIV, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1, '{16'sh0, 16'sh0, 0, 1}},
        '{OP_DIV, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000, 1,
          '{16'sh0100, 16'sh0, 0, 0}},
        '{OP_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000, 1,
          '{16'sh7fff, 16'sh7fff, 1, 0}},
        '{OP_DIV, 16'sh8000, 16'sh8000, 16'sh0001, 16'sh0000, 1,
          '{16'sh8000, 16'sh8000, 1, 0}},
        '{OP_DIV, 16'shffff, 16'sh0001, 16'sh0300, 16'sh0000, 0, '{0, 0, 0, 0}},
        '{OP_DIV, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0300, 0, '{0, 0, 0, 0}},
        '{OP_DIV, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 0, '{0, 0, 0, 0}},
        '{OP_DIV, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0000, 0, '{0, 0, 0, 0}}
    };

    initial begin
        t_req_op   op;
        t_cplx_res none;
        int        waited;
        none = '{16'sh0, 16'sh0, 1'b0, 1'b0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k])
            send_item(rows[k].op, rows[k].ar, rows[k].ai, rows[k].br, rows[k].bi,
                      rows[k].typed, rows[k].res);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 150 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (n == N_RANDOM / 2) begin
                i_in_valid <= 1'b0;
                while (pending_res.size() != 0) @(posedge i_clk);
            end
            op = t_req_op'($urandom_range(0, 3));
            if (op == OP_DIV && $urandom_range(0, 15) == 0)
                send_item(op, rand_part(), rand_part(), '0, '0, 0, none);
            else
                send_item(op, rand_part(), rand_part(), rand_part(), rand_part(), 0, none);
        end
        i_in_valid <= 1'b0;

        waited = 0;
        while (pending_res.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);

        $display("Checked %0d result items: %0d saturated, %0d zero divisors.",
                 n_results, n_sat, n_div_zero);
        if (n_errors == 0 && pending_res.size() == 0)
            $display("complex_alu_fixed test passed");
        else
            $display("complex_alu_fixed test failed");
        $finish;
    end
endmodule
